/* hw/rtl/tbcd_pkg.sv */
// ----------------------------------------------------------------------------
// tbcd_pkg
// Types and constants for the three-button press and chord detector.
// ----------------------------------------------------------------------------
package tbcd_pkg;

   // Event codes reported per button.
   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_SHORT = 3'd1,
      EV_LONG  = 3'd2,
      EV_C12   = 3'd3,
      EV_C23   = 3'd4,
      EV_ALL   = 3'd5
   } event_type;

   // Register select, taken from bit 2 of the byte address.
   localparam logic REG_DEBOUNCE   = 1'b0;
   localparam logic REG_LONG_PRESS = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DEBOUNCE_W = 10;
   localparam int LONG_W     = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
   localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd1000;

   // One result item.
   typedef struct packed {
      event_type  ev_right;
      event_type  ev_center;
      event_type  ev_left;
      logic [2:0] held_mask;
   } result_type;

endpackage

/* hw/rtl/three_button_press_and_chord_detector_top.sv */
// ----------------------------------------------------------------------------
// three_button_press_and_chord_detector_top
// Debounces three active-low buttons per tick item and reports short, long
// and chord press events, one result item per input item.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake           payload
//   req_      in          req_valid/stall     pin_right/center/left, ack_events
//   rsp_      out         rsp_valid/stall     event_right/center/left, held_mask
//   csr_      in          APB write/read      debounce_ticks, long_press_ticks
//
// An accepted item updates all button state in the same clock and its result
// is registered; one item per cycle while req_stall is low.
// A two-entry output stage (result register plus skid register) lets an item
// be accepted while the previous result waits; req_stall rises only when both
// are full. Reset clears all button state and loads the register defaults.
//
module three_button_press_and_chord_detector_top #(
   parameter int TIMER_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_pin_right,
   input  logic                                 req_pin_center,
   input  logic                                 req_pin_left,
   input  logic                                 req_ack_events,
   // Result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_event_right,
   output logic [2:0]                           rsp_event_center,
   output logic [2:0]                           rsp_event_left,
   output logic [2:0]                           rsp_held_mask,
   // Configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tbcd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tbcd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tbcd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import tbcd_pkg::*;

   localparam int CMP_W = (TIMER_BITS > LONG_W) ? TIMER_BITS : LONG_W;
   localparam logic [TIMER_BITS-1:0] AGE_MAX = {TIMER_BITS{1'b1}};

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      logic [TIMER_BITS-1:0] r;
      r = (v == AGE_MAX) ? v : v + TIMER_BITS'(1);
      return r;
   endfunction

   // Configuration registers
   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [LONG_W-1:0]     long_press_ff;
   logic                  csr_write;

   // Button state
   logic [2:0]            last_raw_ff,  last_raw_in;
   logic [2:0]            held_ff,      held_in;
   logic [2:0]            long_done_ff, long_done_in;
   logic [2:0]            consumed_ff,  consumed_in;
   logic [2:0]            chord_ff,     chord_in;
   logic [TIMER_BITS-1:0] stable_age_ff [3];
   logic [TIMER_BITS-1:0] stable_age_in [3];
   logic [TIMER_BITS-1:0] hold_age_ff   [3];
   logic [TIMER_BITS-1:0] hold_age_in   [3];
   event_type             pending_ff    [3];
   event_type             pending_in    [3];

   // Output stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   result_type            rsp_ff, rsp_in;
   result_type            skid_ff, skid_in;
   result_type            result;

   logic [2:0]            down;
   logic                  multi;
   logic                  accept;
   logic                  take;
   logic [2:0]            long_ok;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_LONG_PRESS) ? CSR_DATA_W'(long_press_ff)
                                                        : CSR_DATA_W'(debounce_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_DEBOUNCE) begin
            debounce_ff <= csr_pwdata[DEBOUNCE_W-1:0];
         end else begin
            long_press_ff <= csr_pwdata[LONG_W-1:0];
         end
      end
   end

   assign accept    = req_valid & ~req_stall;
   assign take      = rsp_valid_ff & ~rsp_stall;
   assign req_stall = skid_valid_ff;

   assign down  = {~req_pin_left, ~req_pin_center, ~req_pin_right};
   assign multi = (down[0] & down[1]) | (down[0] & down[2]) | (down[1] & down[2]);

   // Per-button debounce, short and long press.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pending_in[i]    = req_ack_events ? EV_NONE : pending_ff[i];
         consumed_in[i]   = req_ack_events | consumed_ff[i];
         hold_age_in[i]   = sat_inc(hold_age_ff[i]);
         last_raw_in[i]   = down[i];
         stable_age_in[i] = (down[i] != last_raw_ff[i]) ? '0 : sat_inc(stable_age_ff[i]);
         held_in[i]       = held_ff[i];
         long_done_in[i]  = long_done_ff[i];
         if (CMP_W'(stable_age_in[i]) >= CMP_W'(debounce_ff)) begin
            if (down[i] != held_ff[i]) begin
               if (down[i]) begin
                  hold_age_in[i]  = '0;
                  long_done_in[i] = 1'b0;
                  consumed_in[i]  = 1'b0;
               end else if (!long_done_ff[i] && !consumed_in[i]) begin
                  pending_in[i] = EV_SHORT;
               end
               held_in[i] = down[i];
            end
            if (held_in[i] && !long_done_in[i] && !multi &&
                CMP_W'(hold_age_in[i]) >= CMP_W'(long_press_ff)) begin
               long_done_in[i] = 1'b1;
               pending_in[i]   = EV_LONG;
               consumed_in[i]  = 1'b0;
            end
         end
         long_ok[i] = CMP_W'(hold_age_in[i]) >= CMP_W'(long_press_ff);
      end

      // Chords; the all-three chord overrides the pairs.
      chord_in = chord_ff;
      if (&held_in) begin
         if (!chord_ff[2] && (&long_ok)) begin
            for (int i = 0; i < 3; i++) begin
               pending_in[i] = EV_ALL;
            end
            chord_in[2] = 1'b1;
         end
         chord_in[0] = chord_in[2];
         chord_in[1] = chord_in[2];
      end else begin
         chord_in[2] = 1'b0;
         if (held_in[0] && held_in[1]) begin
            if (!chord_ff[0] && long_ok[0] && long_ok[1]) begin
               pending_in[0] = EV_C12;
               pending_in[1] = EV_C12;
               chord_in[0]   = 1'b1;
            end
         end else begin
            chord_in[0] = 1'b0;
         end
         if (held_in[1] && held_in[2]) begin
            if (!chord_ff[1] && long_ok[1] && long_ok[2]) begin
               pending_in[1] = EV_C23;
               pending_in[2] = EV_C23;
               chord_in[1]   = 1'b1;
            end
         end else begin
            chord_in[1] = 1'b0;
         end
      end

      result.ev_right  = pending_in[0];
      result.ev_center = pending_in[1];
      result.ev_left   = pending_in[2];
      result.held_mask = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff  <= '0;
         held_ff      <= '0;
         long_done_ff <= '0;
         consumed_ff  <= '0;
         chord_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            stable_age_ff[i] <= '0;
            hold_age_ff[i]   <= '0;
            pending_ff[i]    <= EV_NONE;
         end
      end else if (accept) begin
         last_raw_ff  <= last_raw_in;
         held_ff      <= held_in;
         long_done_ff <= long_done_in;
         consumed_ff  <= consumed_in;
         chord_ff     <= chord_in;
         for (int i = 0; i < 3; i++) begin
            stable_age_ff[i] <= stable_age_in[i];
            hold_age_ff[i]   <= hold_age_in[i];
            pending_ff[i]    <= pending_in[i];
         end
      end
   end

   // Output register with skid register behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_right  = rsp_ff.ev_right;
   assign rsp_event_center = rsp_ff.ev_center;
   assign rsp_event_left   = rsp_ff.ev_left;
   assign rsp_held_mask    = rsp_ff.held_mask;

   // The skid register only fills behind a waiting result.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds an item while the result register is empty");

   a_all_chord_held: assert property (@(posedge clock) disable iff (reset)
      chord_ff[2] |-> (&held_ff))
      else $error("all-three chord flag set without all buttons held");

   a_pair_chord_held: assert property (@(posedge clock) disable iff (reset)
      chord_ff[0] |-> (held_ff[0] && held_ff[1]))
      else $error("chord12 flag set without both buttons held");

endmodule
